// ===== rtl/fume_relay_interlock_controller_core_macros.svh =====
// Assertion macros for the fume relay interlock controller checker.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef FUME_RELAY_INTERLOCK_CONTROLLER_CORE_MACROS_SVH
`define FUME_RELAY_INTERLOCK_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FRIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define FRIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fric_pkg.sv =====
// Shared constants and types for the fume relay interlock controller.
// No dependencies; used by the core and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package fric_pkg;

  // Configuration register width and default timer width
  localparam int CFG_W            = 16;
  localparam int TIMER_BITS_DEF   = 16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ALIVE_TIMEOUT = 2'd0,
    CFG_SETTLE        = 2'd1,
    CFG_RELAY_ON      = 2'd2,
    CFG_RELAY_OFF     = 2'd3
  } cfg_idx_e;

  typedef logic [CFG_W-1:0] cfg_data_t;

  // Register values after reset, in milliseconds
  localparam cfg_data_t ALIVE_TIMEOUT_RST = 16'd100;
  localparam cfg_data_t SETTLE_RST        = 16'd1000;
  localparam cfg_data_t RELAY_ON_RST      = 16'd2000;
  localparam cfg_data_t RELAY_OFF_RST     = 16'd5000;

endpackage

`default_nettype wire

// ===== rtl/fric_if.sv =====
// Valid/ready channel interfaces for tick items and result items.
// Depends on nothing; the core uses the sink of fric_in_if and source of fric_out_if.
`timescale 1ns / 1ps
`default_nettype none

interface fric_in_if;
  logic valid;
  logic ready;
  logic alive_pulse;
  logic iron_pin_high;

  modport source (output valid, output alive_pulse, output iron_pin_high, input ready);
  modport sink   (input valid, input alive_pulse, input iron_pin_high, output ready);
endinterface

interface fric_out_if;
  logic valid;
  logic ready;
  logic relay_drive;
  logic station_led_lit;
  logic iron_led_lit;
  logic station_alive;
  logic relay_permitted;

  modport source (output valid, output relay_drive, output station_led_lit,
                  output iron_led_lit, output station_alive, output relay_permitted,
                  input ready);
  modport sink   (input valid, input relay_drive, input station_led_lit,
                  input iron_led_lit, input station_alive, input relay_permitted,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/fume_relay_interlock_controller_core.sv =====
// Fume extractor relay interlock: per-tick station, dock pin and relay logic.
// Depends on fric_pkg and the channel interfaces in fric_if.sv.
//
// Usage:
//   tick_in carries one item per millisecond tick: alive_pulse (a heartbeat edge
//   arrived this tick) and iron_pin_high (dock pin level). result_out carries one
//   item per tick item with the relay drive, both lamps, the station status and
//   the relay permit, as they stand after that tick.
//   The configuration port writes one of four 16-bit delay registers when
//   cfg_we_i is high; write it only while no tick item is in flight.
//   Result: registered; it appears in the cycle after its tick item is accepted.
//   Throughput: one tick item per clock cycle while results are taken; the whole
//   update of all timers and flags is combinational between the input handshake
//   and the result register.
//   Stall: a result held by the receiver stays in the result register, and
//   tick_in.ready drops until it is taken; ready is high again in the cycle it
//   is taken.
//   Reset: all timers clear, the heartbeat age saturates (station not alive),
//   all flags clear and the registers return to 100, 1000, 2000 and 5000 ms.
`timescale 1ns / 1ps
`default_nettype none

module fume_relay_interlock_controller_core #(
  parameter int TIMER_BITS = fric_pkg::TIMER_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire fric_pkg::cfg_idx_e  cfg_idx_i,
  input  wire fric_pkg::cfg_data_t cfg_data_i,
  fric_in_if.sink                 tick_in,
  fric_out_if.source              result_out
);
  import fric_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  typedef logic [TIMER_BITS-1:0] timer_t;

  // Saturating tick increment
  function automatic timer_t bump(input timer_t c);
    timer_t r;
    r = (c == '1) ? c : c + timer_t'(1);
    return r;
  endfunction

  // Strict elapsed test: count past the limit
  function automatic logic past(input timer_t c, input cfg_data_t lim);
    logic r;
    r = CMP_W'(c) > CMP_W'(lim);
    return r;
  endfunction

  // Configuration registers
  cfg_data_t alive_to_q, settle_ms_q, on_dly_q, off_dly_q;

  // State
  timer_t age_q, settle_cnt_q, ovr_cnt_q, pin_cnt_q, rel_cnt_q;
  timer_t age_d, settle_cnt_d, ovr_cnt_d, pin_cnt_d, rel_cnt_d;
  logic   station_q, armed_q, permit_q, ovr_armed_q, pin_prev_q;
  logic   station_d, armed_d, permit_d, ovr_armed_d, pin_prev_d;
  logic   stage1_q, stage2_q, iron_lamp_q, st_lamp_q, req_q, relay_q;
  logic   stage1_d, stage2_d, iron_lamp_d, st_lamp_d, req_d, relay_d;
  logic   req_new;

  // Result register
  logic   out_valid_q;
  logic   in_acc, in_rdy;

  assign in_rdy        = !out_valid_q || result_out.ready;
  assign in_acc        = tick_in.valid && in_rdy;
  assign tick_in.ready = in_rdy;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_to_q  <= ALIVE_TIMEOUT_RST;
      settle_ms_q <= SETTLE_RST;
      on_dly_q    <= RELAY_ON_RST;
      off_dly_q   <= RELAY_OFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALIVE_TIMEOUT: alive_to_q  <= cfg_data_i;
        CFG_SETTLE:        settle_ms_q <= cfg_data_i;
        CFG_RELAY_ON:      on_dly_q    <= cfg_data_i;
        CFG_RELAY_OFF:     off_dly_q   <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // One tick of the interlock
  always_comb begin
    // advance all timers
    age_d        = tick_in.alive_pulse ? '0 : bump(age_q);
    settle_cnt_d = bump(settle_cnt_q);
    ovr_cnt_d    = bump(ovr_cnt_q);
    pin_cnt_d    = bump(pin_cnt_q);
    rel_cnt_d    = bump(rel_cnt_q);

    armed_d     = armed_q;
    permit_d    = permit_q;
    ovr_armed_d = ovr_armed_q;
    st_lamp_d   = st_lamp_q;
    stage1_d    = stage1_q;
    stage2_d    = stage2_q;
    iron_lamp_d = iron_lamp_q;
    req_d       = req_q;
    relay_d     = relay_q;

    // station status and its edges
    station_d = CMP_W'(age_d) < CMP_W'(alive_to_q);
    if (!station_q && station_d) begin
      armed_d      = 1'b1;
      settle_cnt_d = '0;
      ovr_armed_d  = 1'b0;
      st_lamp_d    = 1'b1;
    end else if (station_q && !station_d) begin
      armed_d   = 1'b0;
      st_lamp_d = 1'b0;
      permit_d  = 1'b0;
      if (relay_q) begin
        ovr_armed_d = 1'b1;
        ovr_cnt_d   = '0;
      end
    end
    if (station_d && armed_d && past(settle_cnt_d, settle_ms_q) && !permit_d) begin
      permit_d = 1'b1;
    end

    // qualify the dock pin
    pin_prev_d = tick_in.iron_pin_high;
    priority if (!station_d && (tick_in.iron_pin_high != pin_prev_q)) begin
      pin_cnt_d = '0;
    end else if (station_d && tick_in.iron_pin_high && !pin_prev_q) begin
      stage1_d  = 1'b1;
      pin_cnt_d = '0;
    end else if (station_d && !tick_in.iron_pin_high && pin_prev_q) begin
      stage1_d  = 1'b0;
      pin_cnt_d = '0;
    end else if (station_d && tick_in.iron_pin_high && pin_prev_q && stage1_q &&
                 past(pin_cnt_d, on_dly_q) && !stage2_q) begin
      stage2_d    = 1'b1;
      iron_lamp_d = 1'b1;
    end else if (station_d && !tick_in.iron_pin_high && !pin_prev_q && !stage1_q &&
                 past(pin_cnt_d, on_dly_q) && stage2_q) begin
      stage2_d    = 1'b0;
      iron_lamp_d = 1'b0;
    end else if (!station_d && !tick_in.iron_pin_high && !pin_prev_q &&
                 past(pin_cnt_d, on_dly_q)) begin
      iron_lamp_d = 1'b0;
    end else if (!station_d && tick_in.iron_pin_high && pin_prev_q &&
                 past(pin_cnt_d, on_dly_q)) begin
      iron_lamp_d = 1'b1;
    end else begin
    end

    // relay command; restart its delay only on a change
    priority if (!stage2_d && permit_d && !relay_q) begin
      req_new = 1'b1;
    end else if (stage2_d && permit_d && relay_q) begin
      req_new = 1'b0;
    end else if (!permit_d && relay_q) begin
      req_new = 1'b0;
    end else begin
      req_new = req_q;
    end
    if (req_new != req_q) begin
      req_d     = req_new;
      rel_cnt_d = '0;
    end

    // switch the relay after its delays
    priority if (!req_d && relay_q && past(rel_cnt_d, off_dly_q)) begin
      relay_d = 1'b0;
    end else if (req_d && !relay_q && past(rel_cnt_d, on_dly_q) && permit_d) begin
      relay_d = 1'b1;
    end else if (relay_q && ovr_armed_d && past(ovr_cnt_d, off_dly_q)) begin
      relay_d = 1'b0;
    end else begin
    end
  end

  // Hold state; advance on each accepted tick item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q        <= '1;
      settle_cnt_q <= '0;
      ovr_cnt_q    <= '0;
      pin_cnt_q    <= '0;
      rel_cnt_q    <= '0;
      station_q    <= 1'b0;
      armed_q      <= 1'b0;
      permit_q     <= 1'b0;
      ovr_armed_q  <= 1'b0;
      pin_prev_q   <= 1'b0;
      stage1_q     <= 1'b0;
      stage2_q     <= 1'b0;
      iron_lamp_q  <= 1'b0;
      st_lamp_q    <= 1'b0;
      req_q        <= 1'b0;
      relay_q      <= 1'b0;
    end else if (in_acc) begin
      age_q        <= age_d;
      settle_cnt_q <= settle_cnt_d;
      ovr_cnt_q    <= ovr_cnt_d;
      pin_cnt_q    <= pin_cnt_d;
      rel_cnt_q    <= rel_cnt_d;
      station_q    <= station_d;
      armed_q      <= armed_d;
      permit_q     <= permit_d;
      ovr_armed_q  <= ovr_armed_d;
      pin_prev_q   <= pin_prev_d;
      stage1_q     <= stage1_d;
      stage2_q     <= stage2_d;
      iron_lamp_q  <= iron_lamp_d;
      st_lamp_q    <= st_lamp_d;
      req_q        <= req_d;
      relay_q      <= relay_d;
    end
  end

  // Result valid: set on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (result_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign result_out.valid           = out_valid_q;
  assign result_out.relay_drive     = relay_q;
  assign result_out.station_led_lit = st_lamp_q;
  assign result_out.iron_led_lit    = iron_lamp_q;
  assign result_out.station_alive   = station_q;
  assign result_out.relay_permitted = permit_q;

endmodule

`default_nettype wire

// ===== rtl/fric_checker.sv =====
// Port-level checker for the fume relay interlock controller, bound to the core.
// Depends on the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "fume_relay_interlock_controller_core_macros.svh"

module fric_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic station_led_lit,
  input wire logic station_alive,
  input wire logic relay_permitted
);

  // A stalled result stays offered
  `FRIC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Every accepted item yields a result in the next cycle
  `FRIC_ASSERT_NEXT(a_acc_result, in_valid && in_ready, out_valid, "accepted item gave no result")

  // No item is taken while a stalled result fills the output
  `FRIC_ASSERT_SAME(a_no_overrun, out_valid && !out_ready, !in_ready, "item taken over stalled result")

  // Permit only exists while the station is alive
  `FRIC_ASSERT_SAME(a_permit_alive, out_valid && relay_permitted, station_alive, "permit without station")

  // Station lamp tracks station status
  `FRIC_ASSERT_SAME(a_lamp_alive, out_valid, station_led_lit == station_alive, "station lamp mismatch")

endmodule

bind fume_relay_interlock_controller_core fric_checker u_fric_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (tick_in.valid),
  .in_ready        (tick_in.ready),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .station_led_lit (result_out.station_led_lit),
  .station_alive   (result_out.station_alive),
  .relay_permitted (result_out.relay_permitted)
);

`default_nettype wire

// ===== tb/tb_fume_relay_interlock_controller_core.sv =====
// Self-checking testbench for the fume relay interlock controller core.
// Depends on fric_pkg, the channel interfaces in fric_if.sv and the core itself;
// a local interlock model predicts every result item and the monitor checks it.
`timescale 1ns / 1ps

module tb_fume_relay_interlock_controller_core;
  import fric_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam logic [15:0] TMR_MAX = 16'hFFFF;

  typedef struct packed {
    logic alive_pulse;
    logic iron_pin_high;
  } tick_t;

  // Bit order matches lamp_name below: relay_drive is bit 4
  typedef struct packed {
    logic relay_drive;
    logic station_led_lit;
    logic iron_led_lit;
    logic station_alive;
    logic relay_permitted;
  } lamps_t;

  typedef struct {
    logic [15:0] hb_age;
    logic [15:0] settle_cnt;
    logic [15:0] override_cnt;
    logic [15:0] pin_cnt;
    logic [15:0] relay_cnt;
    bit station_on;
    bit settle_armed;
    bit permit;
    bit override_armed;
    bit pin_prev;
    bit iron_one;
    bit iron_two;
    bit iron_lamp;
    bit station_lamp;
    bit relay_req;
    bit relay_on;
  } interlock_t;

  string lamp_name [0:4] = '{"relay_permitted", "station_alive", "iron_led_lit",
                             "station_led_lit", "relay_drive"};

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  cfg_idx_e  cfg_idx_i;
  cfg_data_t cfg_data_i;

  fric_in_if  tick_if ();
  fric_out_if lamp_if ();

  fume_relay_interlock_controller_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tick_in    (tick_if),
    .result_out (lamp_if)
  );

  // Model state and its copy of the delay registers
  interlock_t  ilk;
  logic [15:0] cur_timeout, cur_settle, cur_on_delay, cur_off_delay;

  tick_t  tick_queue [$];
  lamps_t lamps_due [$];

  int     errors;
  int     ticks_sent;
  int     lamps_checked;
  int     settings_run;
  int     idle_cycles;
  int     fi;
  bit     tick_fire;
  tick_t  nxt_tick;
  lamps_t due, got;

  int     burst_left;
  int     gap_left;
  int     rx_mode;
  int     rx_left;
  int     rx_phase;
  int     hold_left;
  bit     hold_req;

  function automatic logic [15:0] sat_inc(logic [15:0] c);
    return (c == TMR_MAX) ? c : c + 16'd1;
  endfunction

  function automatic void reset_interlock();
    ilk = '{hb_age: TMR_MAX, settle_cnt: '0, override_cnt: '0, pin_cnt: '0,
            relay_cnt: '0, default: 1'b0};
    cur_timeout   = ALIVE_TIMEOUT_RST;
    cur_settle    = SETTLE_RST;
    cur_on_delay  = RELAY_ON_RST;
    cur_off_delay = RELAY_OFF_RST;
  endfunction

  // Advance the interlock by one millisecond tick and return the lamp item
  function automatic lamps_t step_interlock(bit pulse, bit pin);
    bit was_on;
    bit prev;
    bit req;
    lamps_t r;
    ilk.hb_age       = pulse ? 16'd0 : sat_inc(ilk.hb_age);
    ilk.settle_cnt   = sat_inc(ilk.settle_cnt);
    ilk.override_cnt = sat_inc(ilk.override_cnt);
    ilk.pin_cnt      = sat_inc(ilk.pin_cnt);
    ilk.relay_cnt    = sat_inc(ilk.relay_cnt);

    // station status
    was_on = ilk.station_on;
    ilk.station_on = ilk.hb_age < cur_timeout;
    if (!was_on && ilk.station_on) begin
      ilk.settle_armed   = 1'b1;
      ilk.settle_cnt     = '0;
      ilk.override_armed = 1'b0;
      ilk.station_lamp   = 1'b1;
    end else if (was_on && !ilk.station_on) begin
      ilk.settle_armed = 1'b0;
      ilk.station_lamp = 1'b0;
      ilk.permit       = 1'b0;
      if (ilk.relay_on) begin
        ilk.override_armed = 1'b1;
        ilk.override_cnt   = '0;
      end
    end
    if (ilk.station_on && ilk.settle_armed && ilk.settle_cnt > cur_settle && !ilk.permit)
      ilk.permit = 1'b1;

    // dock pin qualification
    prev = ilk.pin_prev;
    ilk.pin_prev = pin;
    if (!ilk.station_on && pin != prev) begin
      ilk.pin_cnt = '0;
    end else if (ilk.station_on && pin && !prev) begin
      ilk.iron_one = 1'b1;
      ilk.pin_cnt  = '0;
    end else if (ilk.station_on && !pin && prev) begin
      ilk.iron_one = 1'b0;
      ilk.pin_cnt  = '0;
    end else if (ilk.station_on && pin && prev && ilk.iron_one &&
                 ilk.pin_cnt > cur_on_delay && !ilk.iron_two) begin
      ilk.iron_two  = 1'b1;
      ilk.iron_lamp = 1'b1;
    end else if (ilk.station_on && !pin && !prev && !ilk.iron_one &&
                 ilk.pin_cnt > cur_on_delay && ilk.iron_two) begin
      ilk.iron_two  = 1'b0;
      ilk.iron_lamp = 1'b0;
    end else if (!ilk.station_on && !pin && !prev && ilk.pin_cnt > cur_on_delay) begin
      ilk.iron_lamp = 1'b0;
    end else if (!ilk.station_on && pin && prev && ilk.pin_cnt > cur_on_delay) begin
      ilk.iron_lamp = 1'b1;
    end

    // relay command; its delay restarts only when the command changes
    req = ilk.relay_req;
    if (!ilk.iron_two && ilk.permit && !ilk.relay_on) req = 1'b1;
    else if (ilk.iron_two && ilk.permit && ilk.relay_on) req = 1'b0;
    else if (!ilk.permit && ilk.relay_on) req = 1'b0;
    if (req != ilk.relay_req) begin
      ilk.relay_req = req;
      ilk.relay_cnt = '0;
    end
    if (!ilk.relay_req && ilk.relay_on && ilk.relay_cnt > cur_off_delay) begin
      ilk.relay_on = 1'b0;
    end else if (ilk.relay_req && !ilk.relay_on && ilk.relay_cnt > cur_on_delay &&
                 ilk.permit) begin
      ilk.relay_on = 1'b1;
    end else if (ilk.relay_on && ilk.override_armed &&
                 ilk.override_cnt > cur_off_delay) begin
      ilk.relay_on = 1'b0;
    end

    r.relay_drive     = ilk.relay_on;
    r.station_led_lit = ilk.station_lamp;
    r.iron_led_lit    = ilk.iron_lamp;
    r.station_alive   = ilk.station_on;
    r.relay_permitted = ilk.permit;
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Monitor: apply register writes, check lamp items, predict accepted ticks
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tick_fire = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ALIVE_TIMEOUT: cur_timeout   = cfg_data_i;
          CFG_SETTLE:        cur_settle    = cfg_data_i;
          CFG_RELAY_ON:      cur_on_delay  = cfg_data_i;
          CFG_RELAY_OFF:     cur_off_delay = cfg_data_i;
          default: ;
        endcase
      end
      if (lamp_if.valid && lamp_if.ready) begin
        got = {lamp_if.relay_drive, lamp_if.station_led_lit, lamp_if.iron_led_lit,
               lamp_if.station_alive, lamp_if.relay_permitted};
        if (lamps_due.size() == 0) begin
          $error("lamp item %0b arrived with no tick outstanding", got);
          errors++;
        end else begin
          due = lamps_due.pop_front();
          for (fi = 0; fi < 5; fi++) begin
            if (due[fi] !== got[fi]) begin
              $error("%s: expected %0b, actual %0b", lamp_name[fi], due[fi], got[fi]);
              errors++;
            end
          end
        end
        lamps_checked++;
      end
      tick_fire = tick_if.valid && tick_if.ready;
      if (tick_fire) begin
        lamps_due.push_back(step_interlock(tick_if.alive_pulse, tick_if.iron_pin_high));
        ticks_sent++;
      end
    end
  end

  // Driver: offer queued ticks in bursts separated by random gaps
  always @(negedge clk_i) begin
    if (rst_ni && !(tick_if.valid && !tick_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        tick_if.valid <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        nxt_tick = tick_queue.pop_front();
        tick_if.alive_pulse   <= nxt_tick.alive_pulse;
        tick_if.iron_pin_high <= nxt_tick.iron_pin_high;
        tick_if.valid         <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a pattern that changes mode now and then; long hold on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_phase++;
      if (hold_left > 0) begin
        hold_left--;
        lamp_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
        lamp_if.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(10, 60);
        end
        rx_left--;
        case (rx_mode)
          0:       lamp_if.ready <= 1'b1;
          1:       lamp_if.ready <= ($urandom_range(0, 3) != 0);
          2:       lamp_if.ready <= (rx_phase % 5) < 3;
          default: lamp_if.ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_if.valid && tick_if.ready) || (lamp_if.valid && lamp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Hold until every queued tick is taken and every lamp item is back
  task automatic drain();
    while (tick_queue.size() != 0 || tick_if.valid || lamps_due.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_settings(cfg_data_t tmo, cfg_data_t settle, cfg_data_t on_d,
                                cfg_data_t off_d);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ALIVE_TIMEOUT;
    cfg_data_i <= tmo;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_SETTLE;
    cfg_data_i <= settle;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_RELAY_ON;
    cfg_data_i <= on_d;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_RELAY_OFF;
    cfg_data_i <= off_d;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_run++;
  endtask

  task automatic random_settings();
    apply_settings(cfg_data_t'($urandom_range(1, 12)), cfg_data_t'($urandom_range(0, 15)),
                   cfg_data_t'($urandom_range(0, 12)), cfg_data_t'($urandom_range(0, 15)));
  endtask

  // Queue a run of ticks: heartbeat every period ticks (0 = none), pin held level
  task automatic push_run(int period, bit pin, int len);
    int i;
    tick_t t;
    for (i = 0; i < len; i++) begin
      t.alive_pulse   = (period != 0) && (i % period == 0);
      t.iron_pin_high = pin;
      tick_queue.push_back(t);
    end
  endtask

  // Queue segments of alive, dead and noisy heartbeat with pin runs and glitches
  task automatic queue_ticks(int count);
    int len;
    int sel;
    int cap;
    int period;
    int i;
    bit level;
    tick_t t;
    while (count > 0) begin
      sel   = $urandom_range(0, 9);
      level = ($urandom_range(0, 1) != 0);
      cap   = (cur_on_delay > 32) ? 40 : cur_on_delay + 8;
      len   = $urandom_range(3, cap);
      if (sel >= 6 && sel < 8) len = (cur_timeout > 32) ? 40 : cur_timeout + $urandom_range(1, 8);
      if (len > count) len = count;
      cap    = (cur_timeout > 8) ? 8 : ((cur_timeout == 0) ? 1 : cur_timeout);
      period = $urandom_range(1, cap);
      for (i = 0; i < len; i++) begin
        if (sel < 6)      t.alive_pulse = (i % period == 0) || ($urandom_range(0, 15) == 0);
        else if (sel < 8) t.alive_pulse = 1'b0;
        else              t.alive_pulse = ($urandom_range(0, 2) == 0);
        t.iron_pin_high = level ^ ($urandom_range(0, 15) == 0);
        tick_queue.push_back(t);
      end
      count -= len;
    end
  endtask

  // Stimulus sequence
  initial begin
    errors        = 0;
    ticks_sent    = 0;
    lamps_checked = 0;
    settings_run  = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    gap_left      = 0;
    rx_mode       = 0;
    rx_left       = 0;
    rx_phase      = 0;
    hold_left     = 0;
    hold_req      = 1'b0;
    tick_fire     = 1'b0;
    reset_interlock();
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_ALIVE_TIMEOUT;
    cfg_data_i            = '0;
    tick_if.valid         = 1'b0;
    tick_if.alive_pulse   = 1'b0;
    tick_if.iron_pin_high = 1'b0;
    lamp_if.ready         = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: station comes alive, none of the long delays can elapse
    queue_ticks(40);
    drain();

    // Directed: pin toggles while dead, turn-on, permit, relay on, iron out,
    // relay off, iron back, then station loss with the relay forced off
    apply_settings(16'd3, 16'd2, 16'd2, 16'd3);
    push_run(0, 1'b1, 2);
    push_run(0, 1'b0, 1);
    push_run(1, 1'b0, 7);
    push_run(2, 1'b1, 6);
    push_run(1, 1'b0, 4);
    push_run(0, 1'b0, 6);
    drain();

    // Shortest timeout and zero delays
    apply_settings(16'd1, 16'd0, 16'd0, 16'd0);
    queue_ticks(80);
    drain();

    // Zero timeout: station never alive
    apply_settings(16'd0, 16'd4, 16'd3, 16'd5);
    queue_ticks(60);
    drain();

    // Random small delays with a long receiver hold-off
    random_settings();
    queue_ticks(100);
    hold_req = 1'b1;
    drain();

    // Largest values: delays never elapse
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_ticks(60);
    drain();

    random_settings();
    queue_ticks(100);
    drain();

    apply_settings(16'd2, 16'd1, 16'd3, 16'd0);
    queue_ticks(80);
    drain();

    random_settings();
    queue_ticks(60);
    drain();

    repeat (8) @(posedge clk_i);
    if (lamps_due.size() != 0) begin
      $error("%0d lamp items never arrived", lamps_due.size());
      errors += lamps_due.size();
    end
    $display("Covered %0d tick items over %0d register settings; %0d lamp items checked.",
             ticks_sent, settings_run, lamps_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== fume_relay_interlock_controller_core.f =====
+incdir+rtl
rtl/fric_pkg.sv
rtl/fric_if.sv
rtl/fume_relay_interlock_controller_core.sv
rtl/fric_checker.sv
tb/tb_fume_relay_interlock_controller_core.sv
